[design/assert_macros.svh]
// Assertion macros used by the design (motor_speed_incremental_pi).
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check sampled on clk, live during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/mspi_pkg.sv]
// Package for the incremental PI speed controller: widths, constants,
// register indexes and the structs passed between stages. No dependencies.
package mspi_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DUTY_LIMIT  = 9500;

  localparam int FRAC_BITS = 8;
  localparam int SPEED_W   = 16;
  localparam int BIAS_W    = 16;
  localparam int TGT_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int DIST_W    = 32;
  localparam int RDIST_W   = 31;
  localparam int BRAKE_W   = 14;
  localparam int DUTY_W    = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int ERR_W   = ((COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W) + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int P_W     = DIFF_W + GAIN_W + 1;
  localparam int I_W     = ERR_W + GAIN_W + 1;
  localparam int DELTA_W = ((P_W > I_W) ? P_W : I_W) + 1;
  localparam int ACC_W   = $clog2(DUTY_LIMIT + 1) + FRAC_BITS + 2;
  localparam int FLOOR_W = BRAKE_W + FRAC_BITS + 1;
  localparam int SUM_W   = ((DELTA_W > ACC_W) ? DELTA_W : ACC_W) + 1;

  localparam int BIAS_MAX  = 160;
  localparam int BIAS_MIN  = 25;
  localparam int BIAS_FLIP = 150;
  localparam int BRAKE_ERR = -40;

  localparam int RESET_RAMP_DISTANCE = 80000;
  localparam int RESET_BRAKE_LEVEL   = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED    = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_INTEGRAL_GAIN = 3'd2,
    REG_SPEED_UP      = 3'd3,
    REG_RAMP_DISTANCE = 3'd4,
    REG_BRAKE_LEVEL   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      brake_en;
  } drive_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [DUTY_W-1:0]       fwd;
    logic [DUTY_W-1:0]       rev;
  } drive_res_t;

  typedef struct packed {
    drive_req_t              req;
    logic signed [TGT_W-1:0] target;
    logic                    ended;
    logic                    armed;
  } stage_t;

endpackage

[design/mspi_in_if.sv]
// Input request channel of the speed controller: one control tick.
// Depends on mspi_pkg.
interface mspi_in_if;
  import mspi_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] measured_count;
  logic signed [BIAS_W-1:0]      speed_bias;
  logic                          ramp_detected;
  logic                          descent_mark;

  modport source (output valid, measured_count, speed_bias, ramp_detected, descent_mark,
                  input ready);
  modport sink (input valid, measured_count, speed_bias, ramp_detected, descent_mark,
                output ready);
endinterface

[design/mspi_out_if.sv]
// Result channel of the speed controller: duties, target and ramp flags.
// Depends on mspi_pkg.
interface mspi_out_if;
  import mspi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       forward_duty;
  logic [DUTY_W-1:0]       reverse_duty;
  logic signed [TGT_W-1:0] target_speed;
  logic                    ramp_ended;
  logic                    ramp_detect_armed;

  modport source (output valid, forward_duty, reverse_duty, target_speed, ramp_ended,
                  ramp_detect_armed, input ready);
  modport sink (input valid, forward_duty, reverse_duty, target_speed, ramp_ended,
                ramp_detect_armed, output ready);
endinterface

[design/mspi_cfg_if.sv]
// Configuration write channel of the speed controller.
// Depends on mspi_pkg.
interface mspi_cfg_if;
  import mspi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/motor_speed_incremental_pi.sv]
// Incremental PI speed controller, one control tick per request.
// Two register stages: the PI product register, then the drive accumulator and output
// register; the drive accumulator loop runs through that one register.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset (rst_n low, synchronous): registers to defaults, state cleared,
// ramp detection armed, both channels empty.
module motor_speed_incremental_pi (
  input  logic       clk,
  input  logic       rst_n,
  mspi_cfg_if.sink   cfg_ch,
  mspi_in_if.sink    in_ch,
  mspi_out_if.source out_ch
);
  import mspi_pkg::*;
  `include "assert_macros.svh"

  localparam logic signed [ERR_W-1:0]   BRAKE_ERR_V = ERR_W'(BRAKE_ERR);
  localparam logic signed [BIAS_W-1:0]  BIAS_MAX_V  = BIAS_W'(BIAS_MAX);
  localparam logic signed [BIAS_W-1:0]  BIAS_MIN_V  = BIAS_W'(BIAS_MIN);
  localparam logic signed [BIAS_W-1:0]  BIAS_FLIP_V = BIAS_W'(BIAS_FLIP);
  localparam logic signed [ACC_W-1:0]   ACC_LIM     = ACC_W'(DUTY_LIMIT * (2 ** FRAC_BITS));

  logic signed [SPEED_W-1:0] base_speed_r;
  logic [GAIN_W-1:0]         prop_gain_r;
  logic [GAIN_W-1:0]         integral_gain_r;
  logic                      speed_up_r;
  logic [RDIST_W-1:0]        ramp_distance_r;
  logic [BRAKE_W-1:0]        brake_level_r;

  logic signed [ERR_W-1:0]  prev_err_r, prev_err_nxt;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;
  logic                     on_ramp_r, on_ramp_nxt;
  logic                     armed_r, armed_nxt;
  logic                     desc_r, desc_nxt;
  logic signed [ACC_W-1:0]  acc_r;

  logic   s1_valid_r;
  stage_t s1_r, s1_nxt;

  logic                    out_valid_r;
  logic [DUTY_W-1:0]       out_fwd_r;
  logic [DUTY_W-1:0]       out_rev_r;
  logic signed [TGT_W-1:0] out_target_r;
  logic                    out_ended_r;
  logic                    out_armed_r;

  logic                     out_en;
  logic                     in_ready;
  logic                     accept;
  logic                     ramp_t;
  logic signed [BIAS_W-1:0] bias;
  logic signed [TGT_W-1:0]  target;
  logic signed [DIST_W-1:0] dist_sum;
  logic                     dist_over;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [P_W-1:0]    p_gain, p_diff, p_term;
  logic signed [I_W-1:0]    i_gain, i_err, i_term;
  logic                     ended;
  drive_res_t               drv;

  assign cfg_ch.ready = 1'b1;
  assign out_en       = !out_valid_r || out_ch.ready;
  assign in_ready     = !s1_valid_r || out_en;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r    <= '0;
      prop_gain_r     <= '0;
      integral_gain_r <= '0;
      speed_up_r      <= 1'b0;
      ramp_distance_r <= RDIST_W'(RESET_RAMP_DISTANCE);
      brake_level_r   <= BRAKE_W'(RESET_BRAKE_LEVEL);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BASE_SPEED:    base_speed_r    <= cfg_ch.data[SPEED_W-1:0];
        REG_PROP_GAIN:     prop_gain_r     <= cfg_ch.data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN: integral_gain_r <= cfg_ch.data[GAIN_W-1:0];
        REG_SPEED_UP:      speed_up_r      <= cfg_ch.data[0];
        REG_RAMP_DISTANCE: ramp_distance_r <= cfg_ch.data[RDIST_W-1:0];
        REG_BRAKE_LEVEL:   brake_level_r   <= cfg_ch.data[BRAKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ramp_t   = on_ramp_r || (in_ch.ramp_detected && armed_r);
    desc_nxt = desc_r || in_ch.descent_mark;

    bias = in_ch.speed_bias;
    if (speed_up_r) begin
      if (bias > BIAS_MAX_V) begin
        bias = BIAS_MAX_V;
      end else if (bias < BIAS_MIN_V) begin
        bias = '0;
      end
      bias = BIAS_FLIP_V - bias;
    end
    target = TGT_W'(base_speed_r) + TGT_W'(bias);

    dist_sum    = dist_r + DIST_W'(in_ch.measured_count);
    dist_over   = dist_sum > $signed({1'b0, ramp_distance_r});
    dist_nxt    = dist_r;
    on_ramp_nxt = ramp_t;
    armed_nxt   = armed_r;
    ended       = 1'b0;
    if (ramp_t) begin
      target   = TGT_W'(base_speed_r);
      dist_nxt = dist_sum;
      if (dist_over) begin
        on_ramp_nxt = 1'b0;
        dist_nxt    = '0;
        armed_nxt   = 1'b0;
        desc_nxt    = 1'b0;
        ended       = 1'b1;
      end
    end else if (!armed_r) begin
      dist_nxt = dist_sum;
      if (dist_over) begin
        dist_nxt  = '0;
        armed_nxt = 1'b1;
      end
    end

    err          = ERR_W'(target) - ERR_W'(in_ch.measured_count);
    diff         = DIFF_W'(err) - DIFF_W'(prev_err_r);
    prev_err_nxt = err;
    p_gain       = P_W'($signed({1'b0, prop_gain_r}));
    p_diff       = P_W'(diff);
    p_term       = p_gain * p_diff;
    i_gain       = I_W'($signed({1'b0, integral_gain_r}));
    i_err        = I_W'(err);
    i_term       = i_gain * i_err;

    s1_nxt.req.delta    = DELTA_W'(p_term) + DELTA_W'(i_term);
    s1_nxt.req.brake_en = desc_nxt && (err < BRAKE_ERR_V);
    s1_nxt.target       = target;
    s1_nxt.ended        = ended;
    s1_nxt.armed        = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      dist_r     <= '0;
      on_ramp_r  <= 1'b0;
      armed_r    <= 1'b1;
      desc_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
      if (accept) begin
        prev_err_r <= prev_err_nxt;
        dist_r     <= dist_nxt;
        on_ramp_r  <= on_ramp_nxt;
        armed_r    <= armed_nxt;
        desc_r     <= desc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  mspi_drive u_drive (
    .acc         (acc_r),
    .req         (s1_r.req),
    .brake_level (brake_level_r),
    .res         (drv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        acc_r <= drv.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_fwd_r    <= drv.fwd;
      out_rev_r    <= drv.rev;
      out_target_r <= s1_r.target;
      out_ended_r  <= s1_r.ended;
      out_armed_r  <= s1_r.armed;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.forward_duty      = out_fwd_r;
  assign out_ch.reverse_duty      = out_rev_r;
  assign out_ch.target_speed      = out_target_r;
  assign out_ch.ramp_ended        = out_ended_r;
  assign out_ch.ramp_detect_armed = out_armed_r;

  `ASSERT_CLK(a_duty_exclusive, out_valid_r |-> (out_fwd_r == '0 || out_rev_r == '0), "duties")
  `ASSERT_CLK(a_acc_in_limit, (acc_r <= ACC_LIM) && (acc_r >= -ACC_LIM), "drive range")
  `ASSERT_CLK(a_end_disarms, (out_valid_r && out_ended_r) |-> !out_armed_r, "still armed")
  `ASSERT_CLK(a_stage_held, (s1_valid_r && !out_en) |=> s1_valid_r, "stalled request dropped")

endmodule

[design/mspi_drive.sv]
// Drive accumulator update: add the PI increment, apply the descent brake
// ceiling, clamp to the duty limit and split into duties. Depends on mspi_pkg.
module mspi_drive (
  input  logic signed [mspi_pkg::ACC_W-1:0]   acc,
  input  mspi_pkg::drive_req_t                req,
  input  logic [mspi_pkg::BRAKE_W-1:0]        brake_level,
  output mspi_pkg::drive_res_t                res
);
  import mspi_pkg::*;

  localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(DUTY_LIMIT * (2 ** FRAC_BITS));
  localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;

  logic signed [SUM_W-1:0]   sum;
  logic signed [FLOOR_W-1:0] floor_v;
  logic signed [SUM_W-1:0]   braked;
  logic signed [SUM_W-1:0]   clamped;
  logic signed [ACC_W:0]     neg;

  always_comb begin
    sum     = SUM_W'(acc) + SUM_W'(req.delta);
    floor_v = -$signed({1'b0, brake_level, {FRAC_BITS{1'b0}}});
    braked  = sum;
    if (req.brake_en && (sum > SUM_W'(floor_v))) begin
      braked = SUM_W'(floor_v);
    end
    if (braked > LIM_POS) begin
      clamped = LIM_POS;
    end else if (braked < LIM_NEG) begin
      clamped = LIM_NEG;
    end else begin
      clamped = braked;
    end
    res.acc = ACC_W'(clamped);
    neg     = -(ACC_W + 1)'(res.acc);
    if (res.acc >= 0) begin
      res.fwd = DUTY_W'(res.acc >>> FRAC_BITS);
      res.rev = '0;
    end else begin
      res.fwd = '0;
      res.rev = DUTY_W'(neg >>> FRAC_BITS);
    end
  end

endmodule

[verif/mspi_checker.sv]
// Checker for motor_speed_incremental_pi: follows the register writes, predicts one
// result per accepted tick and compares it with the result channel in order.
// Depends on mspi_pkg and the three channel interfaces.
module mspi_checker (
  input  logic clk,
  input  logic rst_n,
  mspi_cfg_if  cfg_ch,
  mspi_in_if   in_ch,
  mspi_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mspi_pkg::*;

  typedef struct {
    logic [DUTY_W-1:0]       fwd;
    logic [DUTY_W-1:0]       rev;
    logic signed [TGT_W-1:0] target;
    logic                    ended;
    logic                    armed;
  } duty_t;

  logic signed [SPEED_W-1:0] speed_base;
  logic [GAIN_W-1:0]         gain_p;
  logic [GAIN_W-1:0]         gain_i;
  logic                      boost_on;
  logic [RDIST_W-1:0]        ramp_span;
  logic [BRAKE_W-1:0]        brake_mag;

  logic signed [ERR_W-1:0]   err_prev;
  logic signed [31:0]        drive_q8;
  logic signed [DIST_W-1:0]  travel;
  logic                      on_ramp;
  logic                      ramp_armed;
  logic                      descending;

  duty_t duty_queue[$];
  duty_t want;
  int    errors = 0;

  function automatic duty_t advance_controller(
    input logic signed [COUNT_WIDTH-1:0] count_in,
    input logic signed [BIAS_W-1:0]      bias_in,
    input logic                          ramp_in,
    input logic                          descent_in
  );
    duty_t  res;
    longint cnt, bias, tgt, err, acc, floor_q8, lim_q8;
    cnt       = count_in;
    bias      = bias_in;
    lim_q8    = longint'(DUTY_LIMIT) << FRAC_BITS;
    res.ended = 1'b0;
    if (ramp_in && ramp_armed) on_ramp = 1'b1;
    if (descent_in) descending = 1'b1;
    if (boost_on) begin
      if (bias > BIAS_MAX) bias = BIAS_MAX;
      else if (bias < BIAS_MIN) bias = 0;
      bias = BIAS_FLIP - bias;
    end
    tgt = speed_base + bias;
    if (on_ramp || !ramp_armed) begin
      travel = travel + cnt;
      if (on_ramp) tgt = speed_base;
      if (travel > $signed({1'b0, ramp_span})) begin
        travel = '0;
        if (on_ramp) begin
          on_ramp    = 1'b0;
          ramp_armed = 1'b0;
          descending = 1'b0;
          res.ended  = 1'b1;
        end else begin
          ramp_armed = 1'b1;
        end
      end
    end
    err = tgt - cnt;
    acc = drive_q8 + longint'(gain_p) * (err - err_prev) + longint'(gain_i) * err;
    err_prev = err;
    if (descending && err < BRAKE_ERR) begin
      floor_q8 = -(longint'(brake_mag) << FRAC_BITS);
      if (acc > floor_q8) acc = floor_q8;
    end
    if (acc > lim_q8) acc = lim_q8;
    else if (acc < -lim_q8) acc = -lim_q8;
    drive_q8   = acc;
    res.fwd    = (acc >= 0) ? DUTY_W'(acc >>> FRAC_BITS) : '0;
    res.rev    = (acc < 0) ? DUTY_W'((-acc) >>> FRAC_BITS) : '0;
    res.target = TGT_W'(tgt);
    res.armed  = ramp_armed;
    return res;
  endfunction

  task automatic note_mismatch(input string field, input longint exp_v, input longint got_v);
    $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      speed_base = '0;
      gain_p     = '0;
      gain_i     = '0;
      boost_on   = 1'b0;
      ramp_span  = RDIST_W'(RESET_RAMP_DISTANCE);
      brake_mag  = BRAKE_W'(RESET_BRAKE_LEVEL);
      err_prev   = '0;
      drive_q8   = '0;
      travel     = '0;
      on_ramp    = 1'b0;
      ramp_armed = 1'b1;
      descending = 1'b0;
      duty_queue.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_BASE_SPEED:    speed_base = cfg_ch.data[SPEED_W-1:0];
          REG_PROP_GAIN:     gain_p     = cfg_ch.data[GAIN_W-1:0];
          REG_INTEGRAL_GAIN: gain_i     = cfg_ch.data[GAIN_W-1:0];
          REG_SPEED_UP:      boost_on   = cfg_ch.data[0];
          REG_RAMP_DISTANCE: ramp_span  = cfg_ch.data[RDIST_W-1:0];
          REG_BRAKE_LEVEL:   brake_mag  = cfg_ch.data[BRAKE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (duty_queue.size() == 0) begin
          $display("%0t: result expected none, got fwd %0d rev %0d target %0d",
                   $time, out_ch.forward_duty, out_ch.reverse_duty, out_ch.target_speed);
          errors++;
        end else begin
          want = duty_queue.pop_front();
          if (out_ch.forward_duty !== want.fwd)
            note_mismatch("forward_duty", want.fwd, out_ch.forward_duty);
          if (out_ch.reverse_duty !== want.rev)
            note_mismatch("reverse_duty", want.rev, out_ch.reverse_duty);
          if (out_ch.target_speed !== want.target)
            note_mismatch("target_speed", want.target, out_ch.target_speed);
          if (out_ch.ramp_ended !== want.ended)
            note_mismatch("ramp_ended", want.ended, out_ch.ramp_ended);
          if (out_ch.ramp_detect_armed !== want.armed)
            note_mismatch("ramp_detect_armed", want.armed, out_ch.ramp_detect_armed);
        end
      end
      if (in_ch.valid && in_ch.ready)
        duty_queue.push_back(advance_controller(in_ch.measured_count, in_ch.speed_bias,
                                                in_ch.ramp_detected, in_ch.descent_mark));
    end
    fail_count <= errors;
    pending    <= duty_queue.size();
  end

endmodule

[verif/tb_top.sv]
// Top of the speed controller testbench: clock, reset, register setup, tick stimulus
// with bursts and stalls, and the verdict. Depends on mspi_pkg, the channel
// interfaces, motor_speed_incremental_pi and mspi_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mspi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_TICKS    = 160;
  localparam int NUM_PHASES     = 7;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int          burst_left;
  int          idle_cycles = 0;
  int          rx_cyc = 0;
  int          step_max;
  bit          gaps_on;
  logic [15:0] rx_mask = '1;

  mspi_cfg_if cfg_ch ();
  mspi_in_if  in_ch ();
  mspi_out_if out_ch ();

  motor_speed_incremental_pi u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mspi_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 200 == 0)
      rx_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    out_ch.ready <= rx_mask[rx_cyc[3:0]];
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [COUNT_WIDTH-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return COUNT_WIDTH'($urandom);
      1:       return COUNT_WIDTH'(-int'($urandom_range(0, 200)));
      default: return COUNT_WIDTH'($urandom_range(0, step_max));
    endcase
  endfunction

  function automatic logic signed [BIAS_W-1:0] pick_bias();
    if ($urandom_range(0, 3) == 0) return BIAS_W'($urandom);
    return BIAS_W'(int'($urandom_range(0, 300)) - 60);
  endfunction

  task automatic send_tick(input logic signed [COUNT_WIDTH-1:0] cnt,
                           input logic signed [BIAS_W-1:0] bias,
                           input logic ramp, input logic descent);
    in_ch.valid          <= 1'b1;
    in_ch.measured_count <= cnt;
    in_ch.speed_bias     <= bias;
    in_ch.ramp_detected  <= ramp;
    in_ch.descent_mark   <= descent;
    do @(posedge clk); while (!in_ch.ready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold off until every outstanding request has its result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input int base, input int pgain, input int igain, input int spd,
                           input int rdist, input int brake);
    settle();
    write_reg(REG_BASE_SPEED, CFG_DAT_W'(base));
    write_reg(REG_PROP_GAIN, CFG_DAT_W'(pgain));
    write_reg(REG_INTEGRAL_GAIN, CFG_DAT_W'(igain));
    write_reg(REG_SPEED_UP, CFG_DAT_W'(spd));
    write_reg(REG_RAMP_DISTANCE, CFG_DAT_W'(rdist));
    write_reg(REG_BRAKE_LEVEL, CFG_DAT_W'(brake));
    cfg_ch.valid <= 1'b0;
    step_max = (rdist > 8000) ? 2000 : rdist / 4 + 1;
  endtask

  task automatic run_traffic(input int n_ticks);
    int sent, len, desc_at;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_ticks) begin
      if ($urandom_range(0, 9) < 7) begin
        len     = $urandom_range(2, 25);
        desc_at = $urandom_range(0, 2 * len);
        send_tick(pick_count(), pick_bias(), 1'b1, 1'b0);
        for (int i = 0; i < len; i++)
          send_tick(pick_count(), pick_bias(), 1'b0, i == desc_at);
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_tick(COUNT_WIDTH'($urandom), BIAS_W'($urandom),
                    $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        sent += len;
      end
      if (!paused && sent >= n_ticks / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.measured_count = '0;
    in_ch.speed_bias     = '0;
    in_ch.ramp_detected  = 1'b0;
    in_ch.descent_mark   = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    burst_left           = 0;
    gaps_on              = 1'b1;
    step_max             = 100;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    configure(200, 256, 64, 1, 500, 1000);
    send_tick(-32768, 32767, 1'b0, 1'b0);
    send_tick(32767, -32768, 1'b0, 1'b0);
    send_tick(0, 0, 1'b0, 1'b0);
    send_tick(-1, -1, 1'b0, 1'b0);
    send_tick(100, 24, 1'b0, 1'b0);
    send_tick(100, 25, 1'b0, 1'b0);
    send_tick(100, 160, 1'b0, 1'b0);
    send_tick(100, 161, 1'b0, 1'b0);
    // ramp with descent brake, then end on distance
    send_tick(100, 0, 1'b1, 1'b0);
    send_tick(300, 0, 1'b0, 1'b1);
    send_tick(50, 0, 1'b0, 1'b0);
    send_tick(100, 0, 1'b0, 1'b0);
    // disarmed: drop the ramp flag, then re-arm on distance; a second ramp then ends and re-arms
    send_tick(200, 0, 1'b1, 1'b0);
    send_tick(400, 0, 1'b0, 1'b0);
    send_tick(0, 0, 1'b1, 1'b0);
    send_tick(600, 0, 1'b0, 1'b0);
    send_tick(0, 0, 1'b0, 1'b1);
    send_tick(1000, 0, 1'b0, 1'b0);
    send_tick(-32768, 0, 1'b0, 1'b0);
    send_tick(32767, 0, 1'b0, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case (ph)
        0: configure(-32768, 65535, 65535, 0, 0, 0);
        1: configure(32767, 0, 0, 1, 32'h7FFF_FFFF, DUTY_LIMIT);
        default: configure(($urandom_range(0, 3) == 0) ? int'(16'($urandom))
                                                      : int'($urandom_range(0, 800)) - 400,
                           ($urandom_range(0, 2) == 0) ? int'(16'($urandom))
                                                      : int'($urandom_range(0, 1024)),
                           ($urandom_range(0, 2) == 0) ? int'(16'($urandom))
                                                      : int'($urandom_range(0, 512)),
                           int'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32'h7FFF_FFFF))
                                                      : int'($urandom_range(100, 4000)),
                           int'($urandom_range(0, DUTY_LIMIT)));
      endcase
      run_traffic(PHASE_TICKS);
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
